[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cpx_pwm_pkg.sv]
package cpx_pwm_pkg;

   // Field widths fixed by the interface
   localparam int FUNC_W   = 1;
   localparam int INDEX_W  = 5;
   localparam int BRIGHT_W = 7;
   localparam int SENSE_W  = 3;
   localparam int COLOUT_W = 3;
   localparam int KEY_W    = 4;

   // Word function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b1;

   // Sense line bit positions (active low)
   localparam int SENSE_RIGHT  = 0;
   localparam int SENSE_BUTTON = 1;
   localparam int SENSE_LEFT   = 2;

   // Key code base values and the step between switches
   localparam logic [1:0] KEY_RIGHT  = 2'd1;
   localparam logic [1:0] KEY_BUTTON = 2'd2;
   localparam logic [1:0] KEY_LEFT   = 2'd3;
   localparam logic [2:0] KEY_STRIDE = 3'd3;

   // PWM top value after reset
   localparam logic [BRIGHT_W-1:0] PWM_TOP_RESET = 7'd99;

   typedef enum logic [1:0] {
      SW_IDLE   = 2'd0,
      SW_LEFT   = 2'd1,
      SW_BUTTON = 2'd2,
      SW_RIGHT  = 2'd3
   } sw_state_type;

endpackage

[rtl/core/charlieplex_pwm_and_switch_scan.sv]
// Charlieplexed LED PWM driver with three-way switch scan.
//
// Request channel (req_valid / req_stall): each word is either a brightness
// write (req_func = write) that stores req_brightness for LED req_led_index
// and gives no response, or a scan tick that advances the column and the PWM
// counter, decodes req_sense_lines for the switch on the new column, and
// gives one response word: column driven low, pins driven high, switch state,
// change flag and last key code. Writes to LEDs past the last one are dropped.
// csr_wr_en / csr_wr_data load the PWM top value; write it only while idle.
//
// Throughput: one word per cycle while req_stall is low, writes and ticks in
// any mix. A tick's response passes through the registered read of the
// brightness lanes and then the LED compare into the output register.
// Stall: while rsp_stall holds a response, the pipeline fills its one inner
// stage and then raises req_stall; nothing is dropped or repeated.
// Reset (synchronous): column 0, PWM counter 0, PWM top 99, all switches idle,
// last key 0, all LEDs dark; the brightness valid bits are cleared at once.
module charlieplex_pwm_and_switch_scan #(
   parameter int NUM_PINS = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [cpx_pwm_pkg::FUNC_W-1:0]         req_func,
   input  logic [cpx_pwm_pkg::INDEX_W-1:0]        req_led_index,
   input  logic [cpx_pwm_pkg::BRIGHT_W-1:0]       req_brightness,
   input  logic [cpx_pwm_pkg::SENSE_W-1:0]        req_sense_lines,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cpx_pwm_pkg::COLOUT_W-1:0]       rsp_active_column,
   output logic [NUM_PINS-1:0]                    rsp_high_mask,
   output logic [1:0]                             rsp_switch_state,
   output logic                                   rsp_state_changed,
   output logic [cpx_pwm_pkg::KEY_W-1:0]          rsp_key_code,
   input  logic                                   csr_wr_en,
   input  logic [cpx_pwm_pkg::BRIGHT_W-1:0]       csr_wr_data
);

   localparam int LPC      = NUM_PINS - 1;
   localparam int NUM_LEDS = NUM_PINS * LPC;
   localparam int COL_W    = $clog2(NUM_PINS);
   localparam int LANE_W   = $clog2(LPC);
   localparam int POS_W    = COL_W + 1;
   localparam int BW       = cpx_pwm_pkg::BRIGHT_W;

   // Handshake
   logic out_ready;
   logic req_accept;
   logic tick_accept;
   logic wr_accept;

   // Write address split
   logic              wr_in_range;
   logic [COL_W-1:0]  wr_col;
   logic [LANE_W-1:0] wr_lane;

   // Scan state
   logic [COL_W-1:0]              column_phase_ff;
   logic [COL_W-1:0]              col_next;
   logic [BW-1:0]                 pwm_count_ff;
   logic [BW-1:0]                 pwm_next;
   logic [BW:0]                   pwm_inc;
   logic [BW-1:0]                 pwm_top_ff;
   cpx_pwm_pkg::sw_state_type     switch_states_ff [NUM_PINS];
   cpx_pwm_pkg::sw_state_type     sw_decoded;
   logic                          sw_pressed;
   logic [1:0]                    key_base;
   logic [cpx_pwm_pkg::KEY_W:0]   key_sum;
   logic [cpx_pwm_pkg::KEY_W-1:0] last_key_ff;
   logic [cpx_pwm_pkg::KEY_W-1:0] last_key_in;

   // Brightness lanes: one memory per LED offset, addressed by column
   logic [BW-1:0]  bright_mem [LPC][NUM_PINS];
   logic [LPC-1:0] bright_vld_ff [NUM_PINS];

   // Inner stage
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [COL_W-1:0]              s1_col_ff;
   logic [BW-1:0]                 s1_pwm_ff;
   cpx_pwm_pkg::sw_state_type     s1_state_ff;
   logic                          s1_changed_ff;
   logic [cpx_pwm_pkg::KEY_W-1:0] s1_key_ff;
   logic [BW-1:0]                 s1_bright_ff [LPC];
   logic [LPC-1:0]                s1_vld_ff;

   // Output stage
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [NUM_PINS-1:0]           mask_in;
   logic [COL_W-1:0]              rsp_col_ff;
   logic [NUM_PINS-1:0]           rsp_mask_ff;
   cpx_pwm_pkg::sw_state_type     rsp_state_ff;
   logic                          rsp_changed_ff;
   logic [cpx_pwm_pkg::KEY_W-1:0] rsp_key_ff;

   // Stall the request side only when the inner stage cannot move on
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !out_ready;
   assign req_accept  = req_valid && !req_stall;
   assign tick_accept = req_accept && (req_func == cpx_pwm_pkg::FUNC_TICK);
   assign wr_accept   = req_accept && (req_func == cpx_pwm_pkg::FUNC_WRITE) && wr_in_range;

   // Split the LED index into column and offset by threshold compares
   always_comb begin
      wr_in_range = int'(req_led_index) < NUM_LEDS;
      wr_col = '0;
      for (int k = 1; k < NUM_PINS; k++) begin
         if (int'(req_led_index) >= k * LPC) begin
            wr_col = COL_W'(k);
         end
      end
      wr_lane = LANE_W'(int'(req_led_index) - int'(wr_col) * LPC);
   end

   // Advance column and PWM counter
   always_comb begin
      col_next = (column_phase_ff == COL_W'(NUM_PINS - 1)) ? '0 : column_phase_ff + 1'b1;
      pwm_inc  = {1'b0, pwm_count_ff} + 1'b1;
      pwm_next = (pwm_inc > {1'b0, pwm_top_ff}) ? '0 : pwm_inc[BW-1:0];
   end

   // Decode the switch with priority right, button, left
   always_comb begin
      sw_pressed = 1'b1;
      if (!req_sense_lines[cpx_pwm_pkg::SENSE_RIGHT]) begin
         sw_decoded = cpx_pwm_pkg::SW_RIGHT;
         key_base   = cpx_pwm_pkg::KEY_RIGHT;
      end else if (!req_sense_lines[cpx_pwm_pkg::SENSE_BUTTON]) begin
         sw_decoded = cpx_pwm_pkg::SW_BUTTON;
         key_base   = cpx_pwm_pkg::KEY_BUTTON;
      end else if (!req_sense_lines[cpx_pwm_pkg::SENSE_LEFT]) begin
         sw_decoded = cpx_pwm_pkg::SW_LEFT;
         key_base   = cpx_pwm_pkg::KEY_LEFT;
      end else begin
         sw_pressed = 1'b0;
         sw_decoded = cpx_pwm_pkg::SW_IDLE;
         key_base   = '0;
      end
      key_sum     = (cpx_pwm_pkg::KEY_W + 1)'(col_next) *
                    (cpx_pwm_pkg::KEY_W + 1)'(cpx_pwm_pkg::KEY_STRIDE) +
                    (cpx_pwm_pkg::KEY_W + 1)'(key_base);
      last_key_in = sw_pressed ? key_sum[cpx_pwm_pkg::KEY_W-1:0] : last_key_ff;
   end

   // Scan state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         column_phase_ff <= '0;
         pwm_count_ff    <= '0;
         pwm_top_ff      <= cpx_pwm_pkg::PWM_TOP_RESET;
         last_key_ff     <= '0;
         for (int i = 0; i < NUM_PINS; i++) begin
            switch_states_ff[i] <= cpx_pwm_pkg::SW_IDLE;
         end
      end else begin
         if (csr_wr_en) begin
            pwm_top_ff <= csr_wr_data;
         end
         if (tick_accept) begin
            column_phase_ff            <= col_next;
            pwm_count_ff               <= pwm_next;
            last_key_ff                <= last_key_in;
            switch_states_ff[col_next] <= sw_decoded;
         end
      end
   end

   // Mark written brightness entries; unwritten ones read as dark
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PINS; i++) begin
            bright_vld_ff[i] <= '0;
         end
      end else if (wr_accept) begin
         bright_vld_ff[wr_col][wr_lane] <= 1'b1;
      end
   end

   // Write one lane, read the whole column row on a tick
   always_ff @(posedge clock) begin
      for (int n = 0; n < LPC; n++) begin
         if (wr_accept && (wr_lane == LANE_W'(n))) begin
            bright_mem[n][wr_col] <= req_brightness;
         end
         if (tick_accept) begin
            s1_bright_ff[n] <= bright_mem[n][col_next];
         end
      end
   end

   // Inner stage capture
   assign s1_valid_in = tick_accept ? 1'b1 : (out_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_col_ff     <= col_next;
         s1_pwm_ff     <= pwm_next;
         s1_state_ff   <= sw_decoded;
         s1_changed_ff <= switch_states_ff[col_next] != sw_decoded;
         s1_key_ff     <= last_key_in;
         s1_vld_ff     <= bright_vld_ff[col_next];
      end
   end

   // Build the high-pin mask from the column's brightness row
   always_comb begin
      logic [POS_W-1:0] pos;
      logic [BW-1:0]    level;
      mask_in = '0;
      for (int n = 0; n < LPC; n++) begin
         level = s1_vld_ff[n] ? s1_bright_ff[n] : '0;
         pos   = POS_W'(s1_col_ff) + POS_W'(n + 1);
         if (pos >= POS_W'(NUM_PINS)) begin
            pos = pos - POS_W'(NUM_PINS);
         end
         if (level > s1_pwm_ff) begin
            mask_in[pos[COL_W-1:0]] = 1'b1;
         end
      end
   end

   // Output register
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_col_ff     <= s1_col_ff;
         rsp_mask_ff    <= mask_in;
         rsp_state_ff   <= s1_state_ff;
         rsp_changed_ff <= s1_changed_ff;
         rsp_key_ff     <= s1_key_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_active_column = cpx_pwm_pkg::COLOUT_W'(rsp_col_ff);
   assign rsp_high_mask     = rsp_mask_ff;
   assign rsp_switch_state  = rsp_state_ff;
   assign rsp_state_changed = rsp_changed_ff;
   assign rsp_key_code      = rsp_key_ff;

endmodule

[rtl/core/cpx_pwm_checker.sv]
`include "assert_macros.svh"

module cpx_pwm_checker #(
   parameter int NUM_PINS = 5
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [cpx_pwm_pkg::COLOUT_W-1:0]  rsp_active_column,
   input logic [NUM_PINS-1:0]               rsp_high_mask,
   input logic [1:0]                        rsp_switch_state,
   input logic                              rsp_state_changed,
   input logic [cpx_pwm_pkg::KEY_W-1:0]     rsp_key_code
);

   localparam int CW = cpx_pwm_pkg::COLOUT_W;
   localparam int KW = cpx_pwm_pkg::KEY_W;

   logic          rsp_fire;
   logic          seen_ff;
   logic          seen_in;
   logic [CW-1:0] last_col_ff;
   logic [CW-1:0] last_col_in;
   logic [CW-1:0] exp_col;
   logic [1:0]    key_base;
   logic [KW:0]   exp_key_sum;
   logic          pressed;

   assign rsp_fire = rsp_valid && !rsp_stall;

   // Track the column of the last delivered word
   assign seen_in     = seen_ff || rsp_fire;
   assign last_col_in = rsp_fire ? rsp_active_column : last_col_ff;
   assign exp_col     = (last_col_ff == CW'(NUM_PINS - 1)) ? '0 : last_col_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         last_col_ff <= '0;
      end else begin
         seen_ff     <= seen_in;
         last_col_ff <= last_col_in;
      end
   end

   // Key code a pressed switch must report
   always_comb begin
      pressed = 1'b1;
      case (rsp_switch_state)
         cpx_pwm_pkg::SW_RIGHT:  key_base = cpx_pwm_pkg::KEY_RIGHT;
         cpx_pwm_pkg::SW_BUTTON: key_base = cpx_pwm_pkg::KEY_BUTTON;
         cpx_pwm_pkg::SW_LEFT:   key_base = cpx_pwm_pkg::KEY_LEFT;
         default: begin
            key_base = '0;
            pressed  = 1'b0;
         end
      endcase
      exp_key_sum = (KW + 1)'(rsp_active_column) * (KW + 1)'(cpx_pwm_pkg::KEY_STRIDE) +
                    (KW + 1)'(key_base);
   end

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_active_column) &&
      $stable(rsp_high_mask) && $stable(rsp_switch_state) &&
      $stable(rsp_state_changed) && $stable(rsp_key_code),
      "response word changed while stalled")

   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall,
      "pipeline not empty after reset")

   `ASSERT_CLK_RST(a_col_seq, clock, reset,
      rsp_fire && seen_ff |-> rsp_active_column == exp_col,
      "column did not advance by one between responses")

   `ASSERT_CLK_RST(a_key_match, clock, reset,
      rsp_valid && pressed |-> rsp_key_code == exp_key_sum[KW-1:0],
      "key code does not match the pressed switch")

endmodule

bind charlieplex_pwm_and_switch_scan cpx_pwm_checker #(.NUM_PINS(NUM_PINS)) u_cpx_pwm_checker (.*);
